[sv/ultrasonic_gesture_switch_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic gesture switch core
// Shorthand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_GESTURE_SWITCH_CORE_MACROS_SVH
`define ULTRASONIC_GESTURE_SWITCH_CORE_MACROS_SVH

// Same-cycle implication.
`define UGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ugs_pkg.sv]
// ----------------------------------------------------------------------------
// ugs_pkg
// Shared widths, register codes, gesture phases and record types of the
// ultrasonic gesture switch.
// ----------------------------------------------------------------------------
package ugs_pkg;

  localparam int unsigned SAMPLES_PER_AVERAGE_DEF = 5;

  localparam int unsigned SUM_W      = 19;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned TMO_W      = 8;
  localparam int unsigned WD_W       = 16;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [THR_W-1:0] THR_RESET = 16'd20;
  localparam logic [TMO_W-1:0] TMO_RESET = 8'd122;
  localparam logic [WD_W-1:0]  WD_RESET  = 16'd244;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG = 2'd2;

  // Transaction kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Gesture phases
  localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ON_HAND    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LIT        = 3'd2;
  localparam logic [PHASE_W-1:0] PH_OFF_HAND   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_OFF_WAIT   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_OFF_HAND2  = 3'd5;

  typedef struct packed {
    logic [THR_W-1:0] dev_thr;
    logic [TMO_W-1:0] timeout_ticks;
    logic [WD_W-1:0]  watchdog_ticks;
  } cfg_t;

  typedef struct packed {
    logic               light_on;
    logic [PHASE_W-1:0] phase;
    logic [DIST_W-1:0]  distance;
    logic [DIST_W-1:0]  baseline;
    logic               average_done;
  } result_t;

endpackage

[sv/ultrasonic_gesture_switch_core.sv]
// ----------------------------------------------------------------------------
// Ultrasonic gesture switch core
// Averages echo pulse widths into distances and runs a six-phase hand gesture
// machine that switches a light, with a tick-driven off-gesture timeout and a
// watchdog that retakes the baseline. Each accepted transaction (a sample or a
// tick) yields one result. One transaction is taken every clock cycle while
// the skid stage is empty; the full state update, with the divide by the
// sample count done as a single constant reciprocal multiply, is combinational
// from the state registers to the output register. Results sit in a two-entry
// output buffer, so input takes one extra transaction while the output stalls.
// ----------------------------------------------------------------------------
`include "ultrasonic_gesture_switch_core_macros.svh"

module ultrasonic_gesture_switch_core import ugs_pkg::*; #(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [DIST_W-1:0]     pulse_width,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  light_on,
  output logic [PHASE_W-1:0]    gesture_phase,
  output logic [DIST_W-1:0]     distance,
  output logic [DIST_W-1:0]     baseline,
  output logic                  average_done
);

  cfg_t    cfg;
  logic    accept;
  result_t result;
  result_t out_data;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dev_thr        <= THR_RESET;
      cfg.timeout_ticks  <= TMO_RESET;
      cfg.watchdog_ticks <= WD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEV_THR:  cfg.dev_thr        <= cfg_data[THR_W-1:0];
        CFG_TIMEOUT:  cfg.timeout_ticks  <= cfg_data[TMO_W-1:0];
        CFG_WATCHDOG: cfg.watchdog_ticks <= cfg_data[WD_W-1:0];
        default: ;
      endcase
    end
  end

  ugs_engine #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .pulse_width (pulse_width),
    .cfg         (cfg),
    .result      (result)
  );

  ugs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign light_on      = out_data.light_on;
  assign gesture_phase = out_data.phase;
  assign distance      = out_data.distance;
  assign baseline      = out_data.baseline;
  assign average_done  = out_data.average_done;

  // A full buffer always has its head entry occupied.
  `UGS_ASSERT_NOW(a_full_has_head, !in_ready, out_valid, "buffer full with empty head")
  // A transaction taken while the head is stalled fills the skid stage.
  `UGS_ASSERT_NEXT(a_stall_fills_skid, accept && out_valid && !out_ready, !in_ready, "skid empty")
  // A result left waiting is still offered next cycle.
  `UGS_ASSERT_NEXT(a_result_kept, out_valid && !out_ready, out_valid, "pending result lost")

endmodule

[sv/ugs_engine.sv]
// ----------------------------------------------------------------------------
// ugs_engine
// Sample averaging, baseline, gesture phase machine, timeout and watchdog.
// Updates all state on each accepted transaction and presents the new view.
// ----------------------------------------------------------------------------
module ugs_engine import ugs_pkg::*; #(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              cmd,
  input  logic [DIST_W-1:0] pulse_width,
  input  cfg_t              cfg,
  output result_t           result
);

  localparam int unsigned CNT_W =
    (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  // Exact floor division of any SUM_W-bit sum by a reciprocal multiply
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int unsigned MULT_W    = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = SUM_W + MULT_W;
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam logic [MULT_W-1:0] MULT_K   = MULT_W'(DIV_MULT);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  logic [PHASE_W-1:0] phase, phase_next;
  logic               light, light_next;
  logic [SUM_W-1:0]   sample_sum, sample_sum_next;
  logic [CNT_W-1:0]   sample_count, sample_count_next;
  logic [DIST_W-1:0]  avg_distance, avg_distance_next;
  logic [DIST_W-1:0]  ref_distance, ref_distance_next;
  logic               have_ref, have_ref_next;
  logic               rebase_pending, rebase_pending_next;
  logic               to_run, to_run_next;
  logic [TMO_W-1:0]   to_count, to_count_next;
  logic [WD_W-1:0]    wd_count, wd_count_next;
  logic               done;

  logic [SUM_W-1:0]   sum_add;
  logic [PROD_W-1:0]  quot_prod;
  logic [DIST_W-1:0]  avg_new;
  logic [DIST_W-1:0]  diff;
  logic               deviation;
  logic [WD_W:0]      wd_inc;

  assign sum_add   = sample_sum + SUM_W'(pulse_width);
  assign quot_prod = PROD_W'(sum_add) * PROD_W'(MULT_K);
  assign avg_new   = quot_prod[DIV_SHIFT +: DIST_W];
  assign diff      = (avg_new >= ref_distance) ? (avg_new - ref_distance)
                                               : (ref_distance - avg_new);
  assign deviation = diff > cfg.dev_thr;
  assign wd_inc    = (WD_W+1)'(wd_count) + (WD_W+1)'(1);

  always_comb begin
    phase_next          = phase;
    light_next          = light;
    sample_sum_next     = sample_sum;
    sample_count_next   = sample_count;
    avg_distance_next   = avg_distance;
    ref_distance_next   = ref_distance;
    have_ref_next       = have_ref;
    rebase_pending_next = rebase_pending;
    to_run_next         = to_run;
    to_count_next       = to_count;
    wd_count_next       = wd_count;
    done                = 1'b0;

    if (cmd == CMD_SAMPLE) begin
      if (sample_count == CNT_LAST) begin
        avg_distance_next = avg_new;
        sample_sum_next   = '0;
        sample_count_next = '0;
        done              = 1'b1;
        if (!have_ref) begin
          // first average only sets the baseline
          ref_distance_next = avg_new;
          have_ref_next     = 1'b1;
        end else if (rebase_pending) begin
          // step back once after a watchdog expiry, saturating at idle
          if (phase != PH_IDLE) begin
            phase_next = phase - PHASE_W'(1);
          end
          rebase_pending_next = 1'b0;
        end else if (deviation) begin
          unique case (phase)
            PH_IDLE:     phase_next = PH_ON_HAND;
            PH_LIT:      phase_next = PH_OFF_HAND;
            PH_OFF_WAIT: phase_next = PH_OFF_HAND2;
            default:     phase_next = phase;
          endcase
        end else begin
          wd_count_next = '0;
          unique case (phase)
            PH_ON_HAND: begin
              light_next = 1'b1;
              phase_next = PH_LIT;
            end
            PH_OFF_HAND: begin
              to_run_next   = 1'b1;
              to_count_next = '0;
              phase_next    = PH_OFF_WAIT;
            end
            PH_OFF_HAND2: begin
              light_next    = 1'b0;
              to_run_next   = 1'b0;
              to_count_next = '0;
              phase_next    = PH_IDLE;
            end
            default: phase_next = phase;
          endcase
        end
      end else begin
        sample_sum_next   = sum_add;
        sample_count_next = sample_count + CNT_W'(1);
      end
    end else begin
      if (to_run) begin
        if (to_count < cfg.timeout_ticks) begin
          to_count_next = to_count + TMO_W'(1);
        end else begin
          // unfinished off gesture: fall back to light on
          phase_next    = PH_LIT;
          to_run_next   = 1'b0;
          to_count_next = '0;
        end
      end
      if (wd_inc >= (WD_W+1)'(cfg.watchdog_ticks)) begin
        ref_distance_next   = avg_distance;
        rebase_pending_next = 1'b1;
        wd_count_next       = '0;
      end else begin
        wd_count_next = wd_inc[WD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      light          <= 1'b0;
      sample_sum     <= '0;
      sample_count   <= '0;
      avg_distance   <= '0;
      ref_distance   <= '0;
      have_ref       <= 1'b0;
      rebase_pending <= 1'b0;
      to_run         <= 1'b0;
      to_count       <= '0;
      wd_count       <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      light          <= light_next;
      sample_sum     <= sample_sum_next;
      sample_count   <= sample_count_next;
      avg_distance   <= avg_distance_next;
      ref_distance   <= ref_distance_next;
      have_ref       <= have_ref_next;
      rebase_pending <= rebase_pending_next;
      to_run         <= to_run_next;
      to_count       <= to_count_next;
      wd_count       <= wd_count_next;
    end
  end

  assign result.light_on     = light_next;
  assign result.phase        = phase_next;
  assign result.distance     = avg_distance_next;
  assign result.baseline     = ref_distance_next;
  assign result.average_done = done;

endmodule

[sv/ugs_out_buf.sv]
// ----------------------------------------------------------------------------
// ugs_out_buf
// Two-entry output register with skid stage; ready toward the input side
// comes from a flop.
// ----------------------------------------------------------------------------
module ugs_out_buf import ugs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    out_fire;

  assign out_fire = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain skid into the head when the head leaves
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ultrasonic gesture switch core. Echo samples and
// timer ticks go in as walks through the on/off gesture with random content,
// mixed with noise. A predictor works out the light, phase, distance and
// baseline for every transaction, and the output stream is compared against
// it. Runs through eight register settings with varied back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import ugs_pkg::*;

  localparam int SPA         = SAMPLES_PER_AVERAGE_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic              cmd;
    logic [DIST_W-1:0] pw;
  } sensor_xact_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEV_THR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  cmd = CMD_SAMPLE;
  logic [DIST_W-1:0]     pulse_width = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  light_on;
  logic [PHASE_W-1:0]    gesture_phase;
  logic [DIST_W-1:0]     distance;
  logic [DIST_W-1:0]     baseline;
  logic                  average_done;

  sensor_xact_t sensor_queue[$];
  result_t      expected_readouts[$];

  int send_idle = 0;
  int recv_stall = 0;
  logic hold_req = 1'b0;
  logic rx_hold = 1'b0;

  // predictor state and register copy
  logic [THR_W-1:0]   cf_thr = THR_RESET;
  logic [TMO_W-1:0]   cf_tmo = TMO_RESET;
  logic [WD_W-1:0]    cf_wd = WD_RESET;
  logic [PHASE_W-1:0] gs_ph = PH_IDLE;
  logic               gs_light = 1'b0;
  logic [SUM_W-1:0]   gs_sum = '0;
  logic [2:0]         gs_cnt = '0;
  logic [DIST_W-1:0]  gs_avg = '0;
  logic [DIST_W-1:0]  gs_base = '0;
  logic               gs_have_base = 1'b0;
  logic               gs_rebase = 1'b0;
  logic               gs_tmo_run = 1'b0;
  logic [TMO_W-1:0]   gs_tmo_cnt = '0;
  logic [WD_W-1:0]    gs_wd_cnt = '0;

  int mismatches = 0;
  int n_queued = 0;
  int n_in = 0;
  int n_out = 0;
  int n_avg = 0;
  int n_light_on = 0;
  int n_light_off = 0;
  int n_timeout = 0;
  int n_rebase = 0;
  int n_settings = 0;

  ultrasonic_gesture_switch_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .pulse_width  (pulse_width),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .light_on     (light_on),
    .gesture_phase(gesture_phase),
    .distance     (distance),
    .baseline     (baseline),
    .average_done (average_done)
  );

  always #5 clk = ~clk;

  // Advance the switch state by one transaction and return its readout.
  function automatic result_t switch_predict(logic is_tick, logic [DIST_W-1:0] pw);
    result_t r;
    logic [DIST_W-1:0] diff;
    logic [WD_W:0] wd_next;
    r.average_done = 1'b0;
    if (is_tick == CMD_SAMPLE) begin
      gs_sum = gs_sum + SUM_W'(pw);
      if (int'(gs_cnt) + 1 >= SPA) begin
        gs_avg = DIST_W'(gs_sum / SPA);
        gs_sum = '0;
        gs_cnt = '0;
        r.average_done = 1'b1;
        n_avg++;
        if (!gs_have_base) begin
          gs_base = gs_avg;
          gs_have_base = 1'b1;
        end else if (gs_rebase) begin
          if (gs_ph != PH_IDLE) gs_ph = gs_ph - PHASE_W'(1);
          gs_rebase = 1'b0;
        end else begin
          diff = (gs_avg >= gs_base) ? gs_avg - gs_base : gs_base - gs_avg;
          if (diff > cf_thr) begin
            case (gs_ph)
              PH_IDLE:     gs_ph = PH_ON_HAND;
              PH_LIT:      gs_ph = PH_OFF_HAND;
              PH_OFF_WAIT: gs_ph = PH_OFF_HAND2;
              default: ;
            endcase
          end else begin
            gs_wd_cnt = '0;
            case (gs_ph)
              PH_ON_HAND: begin
                gs_light = 1'b1;
                gs_ph = PH_LIT;
                n_light_on++;
              end
              PH_OFF_HAND: begin
                gs_tmo_run = 1'b1;
                gs_tmo_cnt = '0;
                gs_ph = PH_OFF_WAIT;
              end
              PH_OFF_HAND2: begin
                gs_light = 1'b0;
                gs_tmo_run = 1'b0;
                gs_tmo_cnt = '0;
                gs_ph = PH_IDLE;
                n_light_off++;
              end
              default: ;
            endcase
          end
        end
      end else begin
        gs_cnt = gs_cnt + 3'd1;
      end
    end else begin
      if (gs_tmo_run) begin
        if (gs_tmo_cnt < cf_tmo) begin
          gs_tmo_cnt = gs_tmo_cnt + TMO_W'(1);
        end else begin
          gs_ph = PH_LIT;
          gs_tmo_run = 1'b0;
          gs_tmo_cnt = '0;
          n_timeout++;
        end
      end
      wd_next = {1'b0, gs_wd_cnt} + (WD_W+1)'(1);
      if (wd_next >= {1'b0, cf_wd}) begin
        gs_base = gs_avg;
        gs_rebase = 1'b1;
        gs_wd_cnt = '0;
        n_rebase++;
      end else begin
        gs_wd_cnt = wd_next[WD_W-1:0];
      end
    end
    r.light_on = gs_light;
    r.phase = gs_ph;
    r.distance = gs_avg;
    r.baseline = gs_base;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 40)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [DIST_W-1:0] clamp_dist(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return DIST_W'(v);
  endfunction

  // Input side: hold each transaction until accepted, then load the next.
  always @(posedge clk) begin : drive_inputs
    sensor_xact_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_readouts.push_back(switch_predict(cmd, pulse_width));
        n_in++;
      end
      if (!in_valid || in_ready) begin
        if (sensor_queue.size() != 0 && int'($urandom_range(99)) >= send_idle) begin
          nxt = sensor_queue.pop_front();
          in_valid <= 1'b1;
          cmd <= nxt.cmd;
          pulse_width <= nxt.pw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each readout against the oldest prediction.
  always @(posedge clk) begin : check_outputs
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (expected_readouts.size() == 0) begin
          report_mismatch("unexpected readout", gesture_phase, 0);
        end else begin
          want = expected_readouts.pop_front();
          if (light_on !== want.light_on)
            report_mismatch("light_on", light_on, want.light_on);
          if (gesture_phase !== want.phase)
            report_mismatch("gesture_phase", gesture_phase, want.phase);
          if (distance !== want.distance)
            report_mismatch("distance", distance, want.distance);
          if (baseline !== want.baseline)
            report_mismatch("baseline", baseline, want.baseline);
          if (average_done !== want.average_done)
            report_mismatch("average_done", average_done, want.average_done);
        end
      end
      out_ready <= !rx_hold && (int'($urandom_range(99)) >= recv_stall);
    end
  end

  // Long receiver hold-off so the core fills up and stalls its input.
  initial begin : long_hold
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("no transaction for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_xact(input logic c, input logic [DIST_W-1:0] pw);
    sensor_xact_t x;
    x.cmd = c;
    x.pw = pw;
    sensor_queue.push_back(x);
    n_queued++;
  endtask

  task automatic push_ticks(input int n);
    int i;
    for (i = 0; i < n; i++) push_xact(CMD_TICK, DIST_W'($urandom));
  endtask

  // Five samples scattered around a target distance, ticks sprinkled in.
  task automatic add_average(input int target, input int spread);
    int i;
    int v;
    for (i = 0; i < SPA; i++) begin
      v = target + int'($urandom_range(2 * spread)) - spread;
      push_xact(CMD_SAMPLE, clamp_dist(v));
      if ($urandom_range(9) == 0) push_ticks(1);
    end
    if ($urandom_range(3) == 0) push_ticks(1 + $urandom_range(1));
  endtask

  // One lap of the gesture from the current phase: hand and clear readings alternate, six in all.
  task automatic add_gesture_walk();
    int home;
    int spread;
    int off;
    int far_t;
    int step;
    int ph_guess;
    int burst;
    home = int'(gs_base);
    ph_guess = int'(gs_ph);
    spread = (int'(cf_thr) / 4 > 1500) ? 1500 : int'(cf_thr) / 4;
    for (step = 0; step < 6; step++) begin
      if (ph_guess % 2 == 0) begin
        off = int'(cf_thr) + 1 + spread + int'($urandom_range(400));
        if (home + off <= 65535 && ($urandom_range(1) == 0 || home - off < 0))
          far_t = home + off;
        else
          far_t = home - off;
        add_average(far_t, spread);
      end else begin
        add_average(home, spread);
        if (ph_guess == 3) begin
          // let the off gesture time out now and then
          if (cf_tmo <= 130 && $urandom_range(cf_tmo < 40 ? 1 : 5) == 0)
            burst = int'(cf_tmo) + 1 + int'($urandom_range(1));
          else
            burst = int'($urandom_range(3));
          push_ticks(burst);
        end
      end
      ph_guess = (ph_guess + 1) % 6;
    end
  endtask

  task automatic add_noise();
    int i;
    int n;
    n = 4 + int'($urandom_range(12));
    for (i = 0; i < n; i++) push_xact(1'($urandom_range(1)), DIST_W'($urandom_range(65535)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEV_THR:  cf_thr = val;
      CFG_TIMEOUT:  cf_tmo = val[TMO_W-1:0];
      CFG_WATCHDOG: cf_wd = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [THR_W-1:0] thr, input logic [TMO_W-1:0] tmo,
                            input logic [WD_W-1:0] wd);
    write_reg(CFG_DEV_THR, thr);
    write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    write_reg(CFG_WATCHDOG, wd);
    n_settings++;
  endtask

  // Pause the sender until every predicted readout has come back.
  task automatic drain();
    while (sensor_queue.size() != 0 || in_valid || expected_readouts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input logic [TMO_W-1:0] tmo,
                           input logic [WD_W-1:0] wd, input int s_idle, input int r_stall,
                           input int n, input bit hold);
    int start;
    drain();
    set_config(thr, tmo, wd);
    @(posedge clk);
    send_idle <= s_idle;
    recv_stall <= r_stall;
    if (hold) hold_req = 1'b1;
    start = n_queued;
    while (n_queued - start < n) begin
      while (sensor_queue.size() >= 8) @(posedge clk);
      if ($urandom_range(4) == 0) add_noise();
      else add_gesture_walk();
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: watchdog before the first average, extreme widths,
    // step back at idle, then a hand and a clear reading
    set_config(16'd20, 8'd0, 16'd3);
    push_ticks(3);
    repeat (SPA) push_xact(CMD_SAMPLE, 16'hFFFF);
    repeat (SPA) push_xact(CMD_SAMPLE, 16'h0000);
    repeat (SPA) push_xact(CMD_SAMPLE, 16'h0000);
    repeat (SPA) push_xact(CMD_SAMPLE, 16'hFFFF);
    push_xact(CMD_SAMPLE, 16'hAAAA);
    push_xact(CMD_SAMPLE, 16'h5555);
    push_xact(CMD_TICK, 16'hFFFF);

    run_phase(THR_RESET, TMO_RESET, WD_RESET, 0, 0, 280, 0);
    run_phase(16'd0, 8'd0, 16'd1, 84, 0, 230, 0);
    run_phase(16'hFFFF, 8'hFF, 16'hFFFF, 0, 84, 170, 0);
    run_phase(16'd50, 8'd3, 16'd0, 19, 19, 230, 0);
    run_phase(16'd100, 8'd8, 16'd40, 0, 0, 280, 1);
    run_phase(THR_W'($urandom_range(400)), TMO_W'($urandom_range(20)),
              WD_W'($urandom_range(300, 1)), 19, 19, 280, 0);
    run_phase(16'd30, 8'd5, 16'd25, 0, 84, 230, 0);
    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d readouts from %0d transactions over %0d register settings:",
             n_out, n_in, n_settings);
    $display("%0d averages, %0d lights on, %0d lights off, %0d timeouts, %0d rebases.",
             n_avg, n_light_on, n_light_off, n_timeout, n_rebase);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
